// ----- src/utf8tok_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 tokenizer package
// Result record, queue push bundle and byte class constants shared by the
// tokenizer core, the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8tok_pkg;

  localparam int MAX_RES  = 3;   // results one byte can cause
  localparam int OQ_DEPTH = 4;   // result queue entries
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_DIGIT  = 2'd1,
    KIND_ASCII  = 2'd2,
    KIND_MULTI  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_TOKEN     = 2'd0,
    ST_DONE      = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic [11:0] token_offset;
    logic [12:0] token_length;
    logic [11:0] token_index;
    kind_t       token_kind;
    status_t     status;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [1:0]                count;
    result_t [MAX_RES-1:0]     res;
  } push_t;

  function automatic result_t make_result(logic [11:0] off, logic [12:0] len,
                                          logic [11:0] idx, kind_t kind,
                                          status_t st);
    result_t r;
    r.token_offset = off;
    r.token_length = len;
    r.token_index  = idx;
    r.token_kind   = kind;
    r.status       = st;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/utf8_char_run_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// UTF-8 character and run tokenizer
// Path: an accepted byte is registered at the input, decoded by the core and
// its results written into the result queue; results of one byte leave one per cycle while the receiver is ready.
// Throughput: one byte per cycle while the queue has room; every byte holds
// the input until the four-entry result queue has room for three.
// Reset: synchronous rst clears decoder state, run state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_char_run_tokenizer_top
  import utf8tok_pkg::*;
#(
  parameter int MAX_TEXT_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [11:0] token_offset, [24:12] token_length,
                                      // [36:25] token_index, [39:37] zero
  output logic [3:0]       m_tuser,   // [1:0] token_kind, [3:2] status
  output logic             m_tlast    // last_result
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;
  logic       fire;
  logic       space_ok;
  push_t      push;
  result_t    out_res;

  assign fire     = in_valid && space_ok;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  utf8tok_core #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .text_byte   (in_byte),
    .end_of_text (in_eot),
    .push        (push)
  );

  utf8tok_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {3'b000, out_res.token_index, out_res.token_length,
                    out_res.token_offset};
  assign m_tuser = {out_res.status, out_res.token_kind};
  assign m_tlast = out_res.last_result;

endmodule

`default_nettype wire

// ----- src/utf8tok_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 tokenizer core
// Holds the decoder and run state, and turns one registered byte into up to
// three results in a single pass of logic.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8tok_core
  import utf8tok_pkg::*;
#(
  parameter int MAX_TEXT_BYTES = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output push_t           push
);

  localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_BYTES);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [1:0]       bytes_still_expected, bytes_still_expected_next;
  logic [1:0]       char_byte_count, char_byte_count_next;
  logic [11:0]      char_start_offset, char_start_offset_next;
  logic             run_active, run_active_next;
  logic             run_is_digit, run_is_digit_next;
  logic [11:0]      run_start_offset, run_start_offset_next;
  logic [12:0]      run_byte_length, run_byte_length_next;
  logic [11:0]      tokens_emitted, tokens_emitted_next;
  logic             failed, failed_next;

  logic [11:0]           here;
  logic                  is_letter;
  logic                  is_digit;
  logic [1:0]            n;
  result_t [MAX_RES-1:0] res;

  assign here      = 12'(byte_position);
  assign is_letter = (text_byte >= CHAR_UPPER_A && text_byte <= CHAR_UPPER_Z) ||
                     (text_byte >= CHAR_LOWER_A && text_byte <= CHAR_LOWER_Z);
  assign is_digit  = (text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE) ||
                     (text_byte == CHAR_DOT);

  always_comb begin
    byte_position_next        = byte_position;
    bytes_still_expected_next = bytes_still_expected;
    char_byte_count_next      = char_byte_count;
    char_start_offset_next    = char_start_offset;
    run_active_next           = run_active;
    run_is_digit_next         = run_is_digit;
    run_start_offset_next     = run_start_offset;
    run_byte_length_next      = run_byte_length;
    tokens_emitted_next       = tokens_emitted;
    failed_next               = failed;
    n                         = '0;
    res                       = '0;

    if (!failed) begin
      if (byte_position >= POS_MAX) begin
        failed_next            = 1'b1;
        char_start_offset_next = here;
      end else begin
        byte_position_next = byte_position + POS_W'(1);
        if (bytes_still_expected == 2'd0) begin
          if (!text_byte[7]) begin
            char_start_offset_next = here;
            if (is_letter || is_digit) begin
              if (run_active && run_is_digit == is_digit) begin
                run_byte_length_next = run_byte_length + 13'd1;
              end else begin
                if (run_active) begin
                  res[n] = make_result(run_start_offset, run_byte_length,
                                       tokens_emitted_next,
                                       run_is_digit ? KIND_DIGIT : KIND_LETTER,
                                       ST_TOKEN);
                  n = n + 2'd1;
                  tokens_emitted_next = tokens_emitted_next + 12'd1;
                end
                run_active_next       = 1'b1;
                run_is_digit_next     = is_digit;
                run_start_offset_next = here;
                run_byte_length_next  = 13'd1;
              end
            end else begin
              // punctuation or control byte: close the run, then a lone token
              if (run_active) begin
                res[n] = make_result(run_start_offset, run_byte_length,
                                     tokens_emitted_next,
                                     run_is_digit ? KIND_DIGIT : KIND_LETTER,
                                     ST_TOKEN);
                n = n + 2'd1;
                tokens_emitted_next  = tokens_emitted_next + 12'd1;
                run_active_next      = 1'b0;
                run_byte_length_next = '0;
              end
              res[n] = make_result(here, 13'd1, tokens_emitted_next, KIND_ASCII,
                                   ST_TOKEN);
              n = n + 2'd1;
              tokens_emitted_next = tokens_emitted_next + 12'd1;
            end
          end else if (text_byte[7:5] == LEAD2_TAG) begin
            bytes_still_expected_next = 2'd1;
            char_byte_count_next      = 2'd1;
            char_start_offset_next    = here;
          end else if (text_byte[7:4] == LEAD3_TAG) begin
            bytes_still_expected_next = 2'd2;
            char_byte_count_next      = 2'd1;
            char_start_offset_next    = here;
          end else begin
            failed_next            = 1'b1;
            char_start_offset_next = here;
          end
        end else if (text_byte[7:6] == CONT_TAG) begin
          char_byte_count_next      = char_byte_count + 2'd1;
          bytes_still_expected_next = bytes_still_expected - 2'd1;
          if (bytes_still_expected == 2'd1) begin
            if (run_active) begin
              res[n] = make_result(run_start_offset, run_byte_length,
                                   tokens_emitted_next,
                                   run_is_digit ? KIND_DIGIT : KIND_LETTER,
                                   ST_TOKEN);
              n = n + 2'd1;
              tokens_emitted_next  = tokens_emitted_next + 12'd1;
              run_active_next      = 1'b0;
              run_byte_length_next = '0;
            end
            res[n] = make_result(char_start_offset, 13'(char_byte_count_next),
                                 tokens_emitted_next, KIND_MULTI, ST_TOKEN);
            n = n + 2'd1;
            tokens_emitted_next  = tokens_emitted_next + 12'd1;
            char_byte_count_next = '0;
          end
        end else begin
          failed_next = 1'b1;
        end

        if (!failed_next && end_of_text) begin
          if (bytes_still_expected_next != 2'd0) begin
            failed_next = 1'b1;
          end else begin
            if (run_active_next) begin
              res[n] = make_result(run_start_offset_next, run_byte_length_next,
                                   tokens_emitted_next,
                                   run_is_digit_next ? KIND_DIGIT : KIND_LETTER,
                                   ST_TOKEN);
              n = n + 2'd1;
              tokens_emitted_next = tokens_emitted_next + 12'd1;
            end
            res[n] = make_result(12'd0, 13'd0, tokens_emitted_next, KIND_LETTER,
                                 ST_DONE);
            n = n + 2'd1;
          end
        end
      end
    end

    if (end_of_text) begin
      if (failed_next) begin
        res[n] = make_result(char_start_offset_next, 13'd0, tokens_emitted_next,
                             KIND_LETTER, ST_MALFORMED);
        n = n + 2'd1;
      end
      res[n - 2'd1].last_result = 1'b1;
      // start the next text from a clean state
      byte_position_next        = '0;
      bytes_still_expected_next = '0;
      char_byte_count_next      = '0;
      char_start_offset_next    = '0;
      run_active_next           = 1'b0;
      run_is_digit_next         = 1'b0;
      run_start_offset_next     = '0;
      run_byte_length_next      = '0;
      tokens_emitted_next       = '0;
      failed_next               = 1'b0;
    end
  end

  assign push.count = fire ? n : 2'd0;
  assign push.res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      bytes_still_expected <= '0;
      char_byte_count      <= '0;
      char_start_offset    <= '0;
      run_active           <= 1'b0;
      run_is_digit         <= 1'b0;
      run_start_offset     <= '0;
      run_byte_length      <= '0;
      tokens_emitted       <= '0;
      failed               <= 1'b0;
    end else if (fire) begin
      byte_position        <= byte_position_next;
      bytes_still_expected <= bytes_still_expected_next;
      char_byte_count      <= char_byte_count_next;
      char_start_offset    <= char_start_offset_next;
      run_active           <= run_active_next;
      run_is_digit         <= run_is_digit_next;
      run_start_offset     <= run_start_offset_next;
      run_byte_length      <= run_byte_length_next;
      tokens_emitted       <= tokens_emitted_next;
      failed               <= failed_next;
    end
  end

  a_eot_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_text |-> push.count != 2'd0)
    else $error("end of text produced no result");

  a_eot_clears_state: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_text |=> byte_position == '0 && !failed && !run_active)
    else $error("state not cleared after end of text");

  a_failed_silent: assert property (@(posedge clk) disable iff (rst)
    fire && failed && !end_of_text |-> push.count == 2'd0)
    else $error("result produced after malformed sequence");

endmodule

`default_nettype wire

// ----- src/utf8tok_outq.sv -----
// ----------------------------------------------------------------------------
// UTF-8 tokenizer result queue
// Small register queue that takes up to three results a cycle and hands
// them out one at a time on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8tok_outq
  import utf8tok_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  push_t      push,
  output logic       space_ok,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_res
);

  result_t               mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr;
  logic [OQ_PTR_W-1:0]   rd_ptr;
  logic [OQ_CNT_W-1:0]   count;
  logic [OQ_CNT_W-1:0]   count_next;
  logic                  pop;

  assign out_valid  = (count != '0);
  assign out_res    = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  // room for the largest burst one byte can cause
  assign space_ok   = (count <= OQ_CNT_W'(OQ_DEPTH - MAX_RES));
  assign count_next = count + OQ_CNT_W'(push.count) - OQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.count) begin
        mem[wr_ptr + OQ_PTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.count);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> space_ok)
    else $error("results pushed without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != OQ_CNT_W'(OQ_DEPTH) |-> OQ_PTR_W'(count) == OQ_PTR_W'(wr_ptr - rd_ptr))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ----- bench/utf8_char_run_tokenizer_top_test.sv -----
// ----------------------------------------------------------------------------
// UTF-8 character and run tokenizer testbench
// Streams texts into the tokenizer and checks every token, done marker and
// malformed result against an in-bench predictor. Directed texts cover run
// splitting, the lead byte ranges, broken and cut-off characters and a long
// receiver hold. Random texts follow, mostly well-formed with some broken
// sequences and raw noise.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_char_run_tokenizer_top_test;
  import utf8tok_pkg::*;

  localparam int TEXT_LIMIT   = 4096;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS   = 50;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [39:0] m_tdata;   // [11:0] token_offset, [24:12] token_length,
                          // [36:25] token_index, [39:37] zero
  wire  [3:0]  m_tuser;   // [1:0] token_kind, [3:2] status
  wire         m_tlast;   // last_result

  utf8_char_run_tokenizer_top #(
    .MAX_TEXT_BYTES(TEXT_LIMIT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  // Predictor state for the text in progress
  logic [12:0] text_pos;
  logic [1:0]  cont_left;
  logic [1:0]  char_len;
  logic [11:0] char_start;
  logic        run_on;
  logic        run_digit;
  logic [11:0] run_start;
  logic [12:0] run_len;
  logic [11:0] token_count;
  logic        text_bad;

  result_t     byte_results[$];
  result_t     tokens_due[$];
  logic [7:0]  text_buf[$];

  int errors       = 0;
  int useful_items = 0;
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;

  function automatic void clear_text_state();
    text_pos    = '0;
    cont_left   = '0;
    char_len    = '0;
    char_start  = '0;
    run_on      = 1'b0;
    run_digit   = 1'b0;
    run_start   = '0;
    run_len     = '0;
    token_count = '0;
    text_bad    = 1'b0;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    text_buf = {text_buf, b};
  endfunction

  function automatic void emit(logic [11:0] off, logic [12:0] len, logic [11:0] idx,
                               kind_t kind, status_t st);
    result_t r;
    r.token_offset = off;
    r.token_length = len;
    r.token_index  = idx;
    r.token_kind   = kind;
    r.status       = st;
    r.last_result  = 1'b0;
    byte_results = {byte_results, r};
  endfunction

  function automatic void emit_token(logic [11:0] off, logic [12:0] len, kind_t kind);
    emit(off, len, token_count, kind, ST_TOKEN);
    token_count = token_count + 12'd1;
  endfunction

  function automatic void close_run();
    if (run_on) begin
      emit_token(run_start, run_len, run_digit ? KIND_DIGIT : KIND_LETTER);
      run_on  = 1'b0;
      run_len = '0;
    end
  endfunction

  function automatic void take_ascii(logic [7:0] b, logic [11:0] here);
    logic letter;
    logic digit;
    letter = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
             (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
    digit  = (b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_DOT;
    if (letter || digit) begin
      if (run_on && run_digit == digit) begin
        run_len = run_len + 13'd1;
      end else begin
        close_run();
        run_on    = 1'b1;
        run_digit = digit;
        run_start = here;
        run_len   = 13'd1;
      end
    end else begin
      close_run();
      emit_token(here, 13'd1, KIND_ASCII);
    end
  endfunction

  // Work out the results of one accepted byte and queue them
  function automatic void predict_byte(logic [7:0] b, logic eot);
    logic [11:0] here;
    byte_results.delete();
    if (!text_bad) begin
      if (text_pos >= TEXT_LIMIT) begin
        text_bad   = 1'b1;
        char_start = text_pos[11:0];
      end else begin
        here     = text_pos[11:0];
        text_pos = text_pos + 13'd1;
        if (cont_left == 2'd0) begin
          if (!b[7]) begin
            char_start = here;
            take_ascii(b, here);
          end else if (b[7:5] == LEAD2_TAG) begin
            cont_left  = 2'd1;
            char_len   = 2'd1;
            char_start = here;
          end else if (b[7:4] == LEAD3_TAG) begin
            cont_left  = 2'd2;
            char_len   = 2'd1;
            char_start = here;
          end else begin
            text_bad   = 1'b1;
            char_start = here;
          end
        end else if (b[7:6] == CONT_TAG) begin
          char_len  = char_len + 2'd1;
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            close_run();
            emit_token(char_start, {11'd0, char_len}, KIND_MULTI);
            char_len = '0;
          end
        end else begin
          text_bad = 1'b1;
        end
        if (!text_bad && eot) begin
          if (cont_left != 2'd0) begin
            text_bad = 1'b1;
          end else begin
            close_run();
            emit(12'd0, 13'd0, token_count, KIND_LETTER, ST_DONE);
          end
        end
      end
    end
    if (eot) begin
      if (text_bad) emit(char_start, 13'd0, token_count, KIND_LETTER, ST_MALFORMED);
      byte_results[byte_results.size() - 1].last_result = 1'b1;
      clear_text_state();
    end
    foreach (byte_results[i]) tokens_due = {tokens_due, byte_results[i]};
  endfunction

  // Offer one item, with a random idle burst ahead of it
  task automatic send_item(input logic [7:0] b, input logic eot);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!text_bad) useful_items++;
    predict_byte(b, eot);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_item(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  function automatic void add_string(string s);
    foreach (s[i]) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void add_random_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      if ($urandom_range(0, 1)) add_byte(CHAR_UPPER_A + 8'($urandom_range(0, 25)));
      else add_byte(CHAR_LOWER_A + 8'($urandom_range(0, 25)));
    end else if (pick <= 4) begin
      if ($urandom_range(0, 10) == 10) add_byte(CHAR_DOT);
      else add_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end else if (pick == 5) begin
      add_byte(8'($urandom_range(0, 127)));
    end else if (pick <= 7) begin
      add_byte(8'hC0 | 8'($urandom_range(0, 31)));
      add_byte(cont_byte());
    end else begin
      add_byte(8'hE0 | 8'($urandom_range(0, 15)));
      add_byte(cont_byte());
      add_byte(cont_byte());
    end
  endfunction

  // Insert one broken sequence; a cut-off lead goes at the end of the text
  function automatic void add_broken_char(output bit cut_off);
    cut_off = 1'b0;
    case ($urandom_range(0, 3))
      0: add_byte(cont_byte());
      1: add_byte(8'hF0 | 8'($urandom_range(0, 15)));
      2: begin
        add_byte(8'hE0 | 8'($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) add_byte(cont_byte());
        add_byte(8'($urandom_range(0, 127)) | ($urandom_range(0, 1) ? 8'hC0 : 8'h00));
      end
      default: cut_off = 1'b1;
    endcase
  endfunction

  task automatic test_runs();
    add_string("Ab9.z,");
    add_byte(8'h00);
    add_byte(8'h7F);
    send_text();
  endtask

  task automatic test_multibyte();
    // run before a char is flushed, run after a char is kept, overlongs pass
    text_buf = '{8'h61, 8'hC0, 8'h80, 8'h62, 8'hE0, 8'h80, 8'h80, 8'h37,
                 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
    send_text();
  endtask

  task automatic test_malformed();
    text_buf = '{8'h80};
    send_text();
    text_buf = '{8'hFF};
    send_text();
    text_buf = '{8'hC3, 8'h41};
    send_text();
    text_buf = '{8'hE2, 8'h82};
    send_text();
    add_string("ab!");
    send_text();
  endtask

  task automatic test_pressure();
    hold_request = 1'b1;
    repeat (30) add_byte(8'h21);
    send_text();
  endtask

  task automatic test_random();
    int  start_items;
    int  len;
    int  mode;
    bit  cut_off;
    start_items = useful_items;
    while (useful_items - start_items < RANDOM_ITEMS) begin
      idle_on = (useful_items - start_items) < RANDOM_ITEMS - CALM_ITEMS;
      len  = $urandom_range(1, 12);
      mode = $urandom_range(0, 9);
      cut_off = 1'b0;
      if (mode == 0) begin
        repeat (len) add_byte(8'($urandom_range(0, 255)));
      end else if (mode == 1) begin
        repeat ($urandom_range(0, len)) add_random_char();
        add_broken_char(cut_off);
        if (!cut_off) repeat ($urandom_range(0, 3)) add_random_char();
        else add_byte(8'hC0 | 8'($urandom_range(0, 47)));
      end else begin
        repeat (len) add_random_char();
      end
      send_text();
    end
  endtask

  // Receiver: random idle bursts and the long hold
  initial begin
    @(negedge clk);
    forever begin
      if (hold_request) begin
        m_tready     <= 1'b0;
        hold_request = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%h/%b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_offset", 32'(want.token_offset), 32'(m_tdata[11:0]));
        check_field("token_length", 32'(want.token_length), 32'(m_tdata[24:12]));
        check_field("token_index", 32'(want.token_index), 32'(m_tdata[36:25]));
        check_field("token_kind", 32'(want.token_kind), 32'(m_tuser[1:0]));
        check_field("status", 32'(want.status), 32'(m_tuser[3:2]));
        check_field("last_result", 32'(want.last_result), 32'(m_tlast));
      end
    end
  end

  initial begin
    int wait_count;
    clear_text_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_runs();
    test_multibyte();
    test_malformed();
    test_pressure();
    test_random();
    s_tvalid <= 1'b0;
    wait_count = 0;
    while (tokens_due.size() != 0 && wait_count < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (tokens_due.size() != 0)
        $display("%0t: %0d results never arrived", $time, tokens_due.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/utf8tok_pkg.sv
src/utf8tok_core.sv
src/utf8tok_outq.sv
src/utf8_char_run_tokenizer_top.sv
bench/utf8_char_run_tokenizer_top_test.sv
